### design/boolean_relation_composition_defines.svh
// assertion macros for the relation composition block
`ifndef BOOLEAN_RELATION_COMPOSITION_DEFINES_SVH
`define BOOLEAN_RELATION_COMPOSITION_DEFINES_SVH

// property must hold at every edge out of reset
`define BRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/brc_pkg.sv
// shared types and constants for the relation composition block
`default_nettype none

package brc_pkg;

  localparam int ROW_W   = 32;
  localparam int INDEX_W = 5;
  localparam int CFG_W   = 6;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 6'd32;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_PRIME,
    ST_ACC,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic load_a;
    logic acc;
  } accum_ctrl_t;

endpackage

`default_nettype wire

### design/brc_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module brc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/brc_accum.sv
// shared and-or accumulator: one b row per cycle while accumulating, or-ed into the result row if its a bit is set
`default_nettype none

module brc_accum #(
  parameter int SIZE_LIMIT = 32
) (
  input  wire logic                          clk_i,
  input  wire brc_pkg::accum_ctrl_t          ctrl_i,
  input  wire logic [brc_pkg::ROW_W-1:0]     a_row_i,
  input  wire logic [brc_pkg::ROW_W-1:0]     b_row_i,
  input  wire logic [brc_pkg::ROW_W-1:0]     mask_i,
  input  wire logic [$clog2(SIZE_LIMIT)-1:0] k_i,
  output logic      [brc_pkg::ROW_W-1:0]     c_row_o
);

  logic [SIZE_LIMIT-1:0]     a_q;
  logic [brc_pkg::ROW_W-1:0] c_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_a) begin
      a_q <= a_row_i[SIZE_LIMIT-1:0] & mask_i[SIZE_LIMIT-1:0];
      c_q <= '0;
    end else if (ctrl_i.acc && a_q[k_i]) begin
      c_q <= c_q | b_row_i;
    end
  end

  assign c_row_o = c_q & mask_i;

endmodule

`default_nettype wire

### design/brc_seq.sv
// sequencer: row loading, then per result row a fetch, a prime, an n-step accumulate and an emit
`default_nettype none

module brc_seq #(
  parameter int SIZE_LIMIT = 32,
  localparam int AddrW  = $clog2(SIZE_LIMIT),
  localparam int CountW = $clog2(SIZE_LIMIT + 1),
  localparam int PosW   = $clog2(2 * SIZE_LIMIT)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [CountW-1:0]    n_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      a_we_o,
  output logic [AddrW-1:0]          a_waddr_o,
  output logic [AddrW-1:0]          a_raddr_o,
  output logic                      b_we_o,
  output logic [AddrW-1:0]          b_waddr_o,
  output logic [AddrW-1:0]          b_raddr_o,
  output brc_pkg::accum_ctrl_t      ctrl_o,
  output logic [AddrW-1:0]          k_o,
  output logic [AddrW-1:0]          row_o,
  output logic                      last_o
);

  brc_pkg::seq_state_e state_q, state_d;
  logic [PosW-1:0]  rows_q, rows_d;
  logic [AddrW-1:0] i_q, i_d;
  logic [AddrW-1:0] k_q, k_d;

  logic [PosW-1:0]   n_ext;
  logic [PosW-1:0]   last_pos;
  logic [PosW-1:0]   pos;
  logic [PosW-1:0]   b_off;
  logic [CountW-1:0] n_m1;
  logic              is_a;
  logic              load_acc;
  logic              batch_done;
  logic              row_last;
  logic              k_last;

  assign n_ext      = PosW'(n_i);
  assign last_pos   = (n_ext << 1) - PosW'(1);
  assign pos        = (rows_q > last_pos) ? last_pos : rows_q;
  assign b_off      = pos - n_ext;
  assign is_a       = pos < n_ext;
  assign n_m1       = n_i - CountW'(1);
  assign load_acc   = (state_q == brc_pkg::ST_LOAD) && in_valid_i;
  assign batch_done = load_acc && !is_a && (pos == last_pos);
  assign row_last   = (i_q == n_m1[AddrW-1:0]);
  assign k_last     = (k_q == n_m1[AddrW-1:0]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      brc_pkg::ST_LOAD: begin
        if (batch_done) begin
          state_d = brc_pkg::ST_FETCH;
        end
      end
      brc_pkg::ST_FETCH: state_d = brc_pkg::ST_PRIME;
      brc_pkg::ST_PRIME: state_d = brc_pkg::ST_ACC;
      brc_pkg::ST_ACC: begin
        if (k_last) begin
          state_d = brc_pkg::ST_EMIT;
        end
      end
      brc_pkg::ST_EMIT: begin
        if (!out_stall_i) begin
          state_d = row_last ? brc_pkg::ST_LOAD : brc_pkg::ST_FETCH;
        end
      end
      default: state_d = brc_pkg::ST_LOAD;
    endcase
  end

  // counters
  always_comb begin
    rows_d = rows_q;
    i_d    = i_q;
    k_d    = k_q;
    if (load_acc) begin
      rows_d = batch_done ? '0 : pos + PosW'(1);
    end
    if (batch_done) begin
      i_d = '0;
    end else if ((state_q == brc_pkg::ST_EMIT) && !out_stall_i) begin
      i_d = i_q + AddrW'(1);
    end
    if (state_q == brc_pkg::ST_PRIME) begin
      k_d = '0;
    end else if (state_q == brc_pkg::ST_ACC) begin
      k_d = k_q + AddrW'(1);
    end
  end

  // outputs
  always_comb begin
    in_stall_o    = (state_q != brc_pkg::ST_LOAD);
    out_valid_o   = (state_q == brc_pkg::ST_EMIT);
    a_we_o        = load_acc && is_a;
    b_we_o        = load_acc && !is_a;
    ctrl_o.load_a = (state_q == brc_pkg::ST_PRIME);
    ctrl_o.acc    = (state_q == brc_pkg::ST_ACC);
    b_raddr_o     = (state_q == brc_pkg::ST_ACC) ? k_q + AddrW'(1) : '0;
  end

  assign a_waddr_o = pos[AddrW-1:0];
  assign b_waddr_o = b_off[AddrW-1:0];
  assign a_raddr_o = i_q;
  assign k_o       = k_q;
  assign row_o     = i_q;
  assign last_o    = row_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brc_pkg::ST_LOAD;
      rows_q  <= '0;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      rows_q  <= rows_d;
      i_q     <= i_d;
      k_q     <= k_d;
    end
  end

endmodule

`default_nettype wire

### design/boolean_relation_composition.sv
// top level of the boolean relation composition block
//
// Rows arrive one item per cycle while the input is not stalled: n rows of
// A, then n rows of B. The item carrying the last row of B starts the
// product, and the input stays stalled until all n result rows have been
// taken. Each result row i is built in steps: row i of A is read from its
// ram and loaded into the accumulator, then in n steps the single and-or
// accumulator takes one row of B per cycle from the B ram read port, folding
// it in where row i of A has the matching bit set, and the row is held on
// the output until it is taken. The matrix size register takes effect on
// the next item; 0 acts as 1, values above min(MAX_ELEMENTS, 32) saturate
// to that limit.
`default_nettype none

`include "boolean_relation_composition_defines.svh"

module boolean_relation_composition #(
  parameter int MAX_ELEMENTS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [brc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [brc_pkg::ROW_W-1:0]     row_bits_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [brc_pkg::INDEX_W-1:0]   row_index_o,
  output logic      [brc_pkg::ROW_W-1:0]     result_row_o,
  output logic                               last_row_o
);

  localparam int SizeLimit = (MAX_ELEMENTS < brc_pkg::ROW_W) ? MAX_ELEMENTS : brc_pkg::ROW_W;
  localparam int AddrW     = $clog2(SizeLimit);
  localparam int CountW    = $clog2(SizeLimit + 1);

  logic [brc_pkg::CFG_W-1:0] matrix_size_q;
  logic [CountW-1:0]         n_eff;
  logic [brc_pkg::ROW_W-1:0] col_mask;
  logic [brc_pkg::ROW_W-1:0] wdata;

  logic                 a_we, b_we;
  logic [AddrW-1:0]     a_waddr, a_raddr, b_waddr, b_raddr;
  logic [brc_pkg::ROW_W-1:0] a_rdata, b_rdata;
  brc_pkg::accum_ctrl_t acc_ctrl;
  logic [AddrW-1:0]     k_idx;
  logic [AddrW-1:0]     row_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= brc_pkg::CFG_SIZE_RESET;
    end else if (cfg_we_i) begin
      matrix_size_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, saturate at the size limit
  always_comb begin
    if (matrix_size_q == '0) begin
      n_eff = CountW'(1);
    end else if (matrix_size_q > brc_pkg::CFG_W'(SizeLimit)) begin
      n_eff = CountW'(SizeLimit);
    end else begin
      n_eff = CountW'(matrix_size_q);
    end
  end

  assign col_mask = ~({brc_pkg::ROW_W{1'b1}} << n_eff);
  assign wdata    = row_bits_i & col_mask;

  brc_seq #(
    .SIZE_LIMIT (SizeLimit)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .a_we_o      (a_we),
    .a_waddr_o   (a_waddr),
    .a_raddr_o   (a_raddr),
    .b_we_o      (b_we),
    .b_waddr_o   (b_waddr),
    .b_raddr_o   (b_raddr),
    .ctrl_o      (acc_ctrl),
    .k_o         (k_idx),
    .row_o       (row_idx),
    .last_o      (last_row_o)
  );

  brc_ram #(
    .WIDTH (brc_pkg::ROW_W),
    .DEPTH (SizeLimit)
  ) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  brc_ram #(
    .WIDTH (brc_pkg::ROW_W),
    .DEPTH (SizeLimit)
  ) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  brc_accum #(
    .SIZE_LIMIT (SizeLimit)
  ) u_accum (
    .clk_i   (clk_i),
    .ctrl_i  (acc_ctrl),
    .a_row_i (a_rdata),
    .b_row_i (b_rdata),
    .mask_i  (col_mask),
    .k_i     (k_idx),
    .c_row_o (result_row_o)
  );

  assign row_index_o = brc_pkg::INDEX_W'(row_idx);

  `BRC_ASSERT(a_no_load_while_emit, !out_valid_o || in_stall_o, "item taken while a result waits")
  `BRC_ASSERT(a_result_masked, !out_valid_o || ((result_row_o & ~col_mask) == '0), "result bit beyond size")
  `BRC_ASSERT_NEXT(a_busy_after_mid_row, out_valid_o && !out_stall_i && !last_row_o, in_stall_o && !out_valid_o, "sequencer left compute early")
  `BRC_ASSERT_NEXT(a_load_after_last_row, out_valid_o && !out_stall_i && last_row_o, !in_stall_o && !out_valid_o, "no return to loading")

endmodule

`default_nettype wire

### dv/tb_top.sv
// testbench for boolean_relation_composition: random row streams checked against a boolean product
module tb_top;

  localparam int MAX_ELEMENTS = 32;
  localparam int SIZE_LIMIT = (MAX_ELEMENTS < brc_pkg::ROW_W) ? MAX_ELEMENTS : brc_pkg::ROW_W;
  localparam int QUIET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 50;
  localparam int RANDOM_ITEMS = 300;
  localparam int REPORT_LIMIT = 10;

  typedef enum bit {ENTRY_ROW, ENTRY_SIZE} entry_kind_e;

  typedef struct {
    entry_kind_e               kind;
    logic [brc_pkg::ROW_W-1:0] data;
    int unsigned               send_pct;
    int unsigned               recv_pct;
  } entry_t;

  typedef struct {
    logic [brc_pkg::INDEX_W-1:0] index;
    logic [brc_pkg::ROW_W-1:0]   row;
    logic                        last;
  } product_row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [brc_pkg::CFG_W-1:0]   cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [brc_pkg::ROW_W-1:0]   row_bits_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [brc_pkg::INDEX_W-1:0] row_index_o;
  logic [brc_pkg::ROW_W-1:0]   result_row_o;
  logic                        last_row_o;

  entry_t       pending_q[$];
  product_row_t product_q[$];

  logic [brc_pkg::ROW_W-1:0] rel_a [SIZE_LIMIT];
  logic [brc_pkg::ROW_W-1:0] rel_b [SIZE_LIMIT];
  logic [brc_pkg::CFG_W-1:0] rows_seen = '0;
  logic [brc_pkg::CFG_W-1:0] size_reg = brc_pkg::CFG_SIZE_RESET;

  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  int unsigned quiet = 0;
  int unsigned failures = 0;

  logic [brc_pkg::CFG_W-1:0] gen_size = brc_pkg::CFG_SIZE_RESET;
  int unsigned               gen_seen = 0;
  int unsigned               gen_send = 0;
  int unsigned               gen_recv = 0;
  int unsigned               gen_items = 0;

  boolean_relation_composition #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .row_bits_i  (row_bits_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_index_o (row_index_o),
    .result_row_o(result_row_o),
    .last_row_o  (last_row_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned relation_size(logic [brc_pkg::CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > SIZE_LIMIT) return SIZE_LIMIT;
    return 32'(v);
  endfunction

  task automatic compose_on_row(input logic [brc_pkg::ROW_W-1:0] bits);
    int unsigned n, pos, last_pos;
    logic [63:0] wide;
    logic [brc_pkg::ROW_W-1:0] mask, acc;
    product_row_t r;
    n = relation_size(size_reg);
    wide = (64'd1 << n) - 64'd1;
    mask = wide[brc_pkg::ROW_W-1:0];
    last_pos = 2 * n - 1;
    pos = 32'(rows_seen);
    if (pos > last_pos) pos = last_pos;
    if (pos < n) begin
      rel_a[pos] = bits & mask;
      rows_seen = brc_pkg::CFG_W'(pos + 1);
    end else begin
      rel_b[pos-n] = bits & mask;
      if (pos < last_pos) begin
        rows_seen = brc_pkg::CFG_W'(pos + 1);
      end else begin
        for (int i = 0; i < n; i++) begin
          acc = '0;
          for (int k = 0; k < n; k++) begin
            if (rel_a[i][k]) acc |= rel_b[k];
          end
          r.index = brc_pkg::INDEX_W'(i);
          r.row = acc & mask;
          r.last = (i == n - 1);
          product_q.push_back(r);
        end
        rows_seen = '0;
      end
    end
  endtask

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endfunction

  // driver
  always @(posedge clk_i) begin : drive_rows
    entry_t head;
    logic nxt_valid, nxt_we, took;
    logic [brc_pkg::ROW_W-1:0] nxt_bits;
    logic [brc_pkg::CFG_W-1:0] nxt_wdata;
    nxt_valid = in_valid_i;
    nxt_bits = row_bits_i;
    nxt_we = 1'b0;
    nxt_wdata = cfg_wdata_i;
    took = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) size_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        compose_on_row(row_bits_i);
        took = 1'b1;
      end
      if (took || in_valid_i || cfg_we_i || product_q.size() != 0) quiet = 0;
      else quiet++;
      if (!(in_valid_i && in_stall_o)) begin
        nxt_valid = 1'b0;
        if (pending_q.size() != 0) begin
          head = pending_q[0];
          send_pct = head.send_pct;
          recv_pct = head.recv_pct;
          if (head.kind == ENTRY_SIZE) begin
            if (quiet >= QUIET_CYCLES) begin
              void'(pending_q.pop_front());
              nxt_we = 1'b1;
              nxt_wdata = head.data[brc_pkg::CFG_W-1:0];
              quiet = 0;
            end
          end else if ($urandom_range(99) >= send_pct) begin
            void'(pending_q.pop_front());
            nxt_valid = 1'b1;
            nxt_bits = head.data;
          end
        end
      end
    end
    in_valid_i <= nxt_valid;
    row_bits_i <= nxt_bits;
    cfg_we_i <= nxt_we;
    cfg_wdata_i <= nxt_wdata;
  end

  // monitor
  always @(posedge clk_i) begin : check_rows
    product_row_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (product_q.size() == 0) begin
          note_failure($sformatf("unexpected result: index %0d row %h last %0b",
                                 row_index_o, result_row_o, last_row_o));
        end else begin
          want = product_q.pop_front();
          if (row_index_o !== want.index || result_row_o !== want.row ||
              last_row_o !== want.last) begin
            note_failure($sformatf(
              "expected index %0d row %h last %0b, got index %0d row %h last %0b",
              want.index, want.row, want.last, row_index_o, result_row_o, last_row_o));
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_pct);
    end
  end

  function automatic void set_pacing(int unsigned mode);
    case (mode)
      0: begin gen_send = 0;  gen_recv = 0;  end
      1: begin gen_send = 49; gen_recv = 0;  end
      2: begin gen_send = 0;  gen_recv = 49; end
      default: begin gen_send = 7; gen_recv = 7; end
    endcase
  endfunction

  function automatic void push_size(logic [brc_pkg::CFG_W-1:0] v);
    entry_t e;
    e.kind = ENTRY_SIZE;
    e.data = brc_pkg::ROW_W'(v);
    e.send_pct = gen_send;
    e.recv_pct = gen_recv;
    pending_q.push_back(e);
    gen_size = v;
  endfunction

  function automatic void push_row(logic [brc_pkg::ROW_W-1:0] v);
    entry_t e;
    int unsigned n, pos;
    e.kind = ENTRY_ROW;
    e.data = v;
    e.send_pct = gen_send;
    e.recv_pct = gen_recv;
    pending_q.push_back(e);
    gen_items++;
    // track batch position so random batches end aligned
    n = relation_size(gen_size);
    pos = (gen_seen > 2 * n - 1) ? 2 * n - 1 : gen_seen;
    gen_seen = (pos == 2 * n - 1) ? 0 : pos + 1;
  endfunction

  function automatic logic [brc_pkg::ROW_W-1:0] random_row();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return $urandom & $urandom & $urandom;
      3: return 32'd1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned batch, pick, n;
    logic [brc_pkg::CFG_W-1:0] sz;
    // full batch at the reset size writes every stored row
    for (int i = 0; i < 2 * SIZE_LIMIT; i++) push_row(random_row());

    set_pacing(3);
    // size zero acts as one, high bits ignored
    push_size(6'd0);
    push_row(32'hFFFF_FFFF);
    push_row(32'hFFFF_FFFF);
    push_row(32'hFFFF_FFFE);
    push_row(32'hFFFF_FFFF);
    push_size(6'd3);
    push_row(32'h8000_0001);
    push_row(32'h4000_0006);
    push_row(32'h0000_0000);
    push_row(32'hFFFF_FFFF);
    push_row(32'h0000_0002);
    push_row(32'hA5A5_A5A4);
    // shrink mid-batch past the last row of b
    push_size(6'd4);
    for (int i = 0; i < 6; i++) push_row(random_row());
    push_size(6'd3);
    push_row(random_row());
    // grow mid-batch
    push_size(6'd2);
    push_row(random_row());
    push_row(random_row());
    push_size(6'd4);
    for (int i = 0; i < 6; i++) push_row(random_row());

    batch = 0;
    while (gen_items < RANDOM_ITEMS) begin
      set_pacing($urandom_range(3));
      pick = $urandom_range(99);
      if (batch == 0) sz = 6'd63;
      else if (batch == 1) sz = 6'd32;
      else if (pick < 4) sz = 6'd0;
      else if (pick < 8) sz = brc_pkg::CFG_W'(32 + $urandom_range(31));
      else if (pick < 12) sz = brc_pkg::CFG_W'($urandom_range(9, 31));
      else sz = brc_pkg::CFG_W'($urandom_range(1, 8));
      if (batch < 2 || $urandom_range(99) < 40) push_size(sz);
      if ($urandom_range(99) < 15) begin
        n = relation_size(gen_size);
        for (int i = $urandom_range(2 * n - 1); i > 0; i--) push_row(random_row());
        push_size(brc_pkg::CFG_W'($urandom_range(8)));
      end
      do push_row(random_row()); while (gen_seen != 0);
      batch++;
    end

    wait (rst_ni);
    while (pending_q.size() != 0 || in_valid_i || product_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0 && product_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : reset_seq
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : watchdog
    #40000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
